[rtl/plc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the positional list store.
// No dependencies; every other file takes names from here by scope.
package plc_pkg;

	localparam int unsigned DATA_W       = 32;
	localparam int unsigned KIND_W       = 3;
	localparam int unsigned POS_W        = 5;
	localparam int unsigned STAT_W       = 3;
	localparam int unsigned CNT_W        = 5;
	localparam int unsigned CAPACITY_DEF = 16;

	// Request kinds
	typedef enum logic [KIND_W-1:0] {
		K_INSERT    = 3'd0,
		K_APPEND    = 3'd1,
		K_DEL_POS   = 3'd2,
		K_DEL_VAL   = 3'd3,
		K_SEARCH    = 3'd4,
		K_DROP_TAIL = 3'd5
	} kind_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_BADPOS  = 3'd3,
		ST_MISSING = 3'd4
	} status_t;

	// What every cell of the row does
	typedef enum logic [1:0] {
		CM_HOLD     = 2'd0,
		CM_INSERT   = 2'd1,
		CM_DELETE   = 2'd2,
		CM_DROP_HIT = 2'd3
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t               mode;
		logic signed [DATA_W-1:0] value;
	} cell_ctl_t;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic                     found;
		logic [CNT_W-1:0]         entry_count;
		logic signed [DATA_W-1:0] head_value;
		logic signed [DATA_W-1:0] tail_value;
		logic signed [DATA_W-1:0] middle_value;
	} rsp_t;

endpackage

[rtl/plc_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels for request and response words.
// Depends on plc_pkg for the payload structs.
interface plc_req_if;
	logic          valid;
	logic          ready;
	plc_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface plc_rsp_if;
	logic          valid;
	logic          ready;
	plc_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/plc_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the list row: holds one entry, shifts with its neighbors.
// Depends on plc_pkg.
module plc_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned IW  = 4,
	parameter int unsigned CW  = 5
) (
	input  logic                              clk,
	input  plc_pkg::cell_ctl_t                ctl,
	input  logic [IW-1:0]                     tgt,
	input  logic [CW-1:0]                     count,
	input  logic signed [plc_pkg::DATA_W-1:0] left_value,
	input  logic signed [plc_pkg::DATA_W-1:0] right_value,
	input  logic                              hit_in,
	output logic                              hit_out,
	input  logic [IW-1:0]                     tail_idx,
	input  logic [IW-1:0]                     mid_idx,
	output logic signed [plc_pkg::DATA_W-1:0] value,
	output logic signed [plc_pkg::DATA_W-1:0] tail_pick,
	output logic signed [plc_pkg::DATA_W-1:0] mid_pick
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);
	localparam logic [CW-1:0] MY_POS = CW'(IDX);

	logic signed [plc_pkg::DATA_W-1:0] value_q;
	logic signed [plc_pkg::DATA_W-1:0] value_d;
	logic                              match;

	// Compare against the request value; pass the first-hit mark down the row
	assign match   = (MY_POS < count) && (value_q == ctl.value);
	assign hit_out = hit_in | match;

	// Pick the next content from self, neighbor or the incoming word
	always_comb begin
		value_d = value_q;
		case (ctl.mode)
			plc_pkg::CM_HOLD: begin
				value_d = value_q;
			end
			plc_pkg::CM_INSERT: begin
				if (MY_IDX == tgt) begin
					value_d = ctl.value;
				end else if (MY_IDX > tgt) begin
					value_d = left_value;
				end
			end
			plc_pkg::CM_DELETE: begin
				if (MY_IDX >= tgt) begin
					value_d = right_value;
				end
			end
			plc_pkg::CM_DROP_HIT: begin
				if (hit_out) begin
					value_d = right_value;
				end
			end
			default: begin
				value_d = value_q;
			end
		endcase
	end

	// Hold the entry
	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value     = value_q;
	assign tail_pick = (MY_IDX == tail_idx) ? value_q : '0;
	assign mid_pick  = (MY_IDX == mid_idx) ? value_q : '0;

endmodule

[rtl/positional_list_store.sv]
`timescale 1ns / 1ps
// Top level of the positional list store: request decode, cell row, response register.
// Depends on plc_pkg, plc_if and plc_cell.

// A bounded ordered list of up to CAPACITY signed 32-bit entries held in a row of
// cells, head in cell 0. A request word is decoded and applied to every cell in the
// cycle it is accepted: insert, delete and first-match delete all complete in that
// cycle by shifting each cell from its left or right neighbor. Once the response
// register is free, head, tail and middle are read out of the updated row into it;
// the request side stays blocked until then, while a finished response waits for the
// one before it to be taken. Entries at or above the entry count are never reported
// and need no reset.
module positional_list_store #(
	parameter int unsigned CAPACITY = plc_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	plc_req_if.sink       req,
	plc_rsp_if.source     rsp
);

	localparam int unsigned IW   = $clog2(CAPACITY);
	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = ((CW > plc_pkg::POS_W) ? CW : plc_pkg::POS_W) + 1;
	localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_d;
	logic                 busy_q;
	plc_pkg::status_t     status_q;
	plc_pkg::status_t     status_d;
	logic                 found_q;
	logic                 found_d;
	logic                 rsp_valid_q;
	plc_pkg::rsp_t        rsp_data_q;
	logic                 accept;
	logic                 load;
	plc_pkg::cell_ctl_t   ctl;
	plc_pkg::cell_mode_t  mode_d;
	logic [IW-1:0]        tgt;
	logic [CMPW-1:0]      pos_x;
	logic [CMPW-1:0]      n_x;
	logic [CW-1:0]        cnt_m1;
	logic [IW-1:0]        tail_idx;
	logic [IW-1:0]        mid_idx;
	logic                 any_hit;
	logic signed [plc_pkg::DATA_W-1:0] tail_v;
	logic signed [plc_pkg::DATA_W-1:0] mid_v;

	logic signed [plc_pkg::DATA_W-1:0] cell_val  [CAPACITY];
	logic signed [plc_pkg::DATA_W-1:0] tail_pick [CAPACITY];
	logic signed [plc_pkg::DATA_W-1:0] mid_pick  [CAPACITY];
	logic [CAPACITY:0]                 hit_chain;

	assign accept    = req.valid && req.ready;
	assign req.ready = !busy_q;
	assign load      = busy_q && (!rsp_valid_q || rsp.ready);

	assign pos_x = CMPW'(req.data.position);
	assign n_x   = CMPW'(count_q);
	assign any_hit = hit_chain[CAPACITY];

	// Decode the request against the current entry count
	always_comb begin
		mode_d   = plc_pkg::CM_HOLD;
		tgt      = '0;
		status_d = plc_pkg::ST_OK;
		found_d  = 1'b0;
		count_d  = count_q;
		case (plc_pkg::kind_t'(req.data.kind))
			plc_pkg::K_INSERT: begin
				if (count_q == FULL_CNT) begin
					status_d = plc_pkg::ST_FULL;
				end else if (pos_x == '0 || pos_x > n_x + CMPW'(1)) begin
					status_d = plc_pkg::ST_BADPOS;
				end else begin
					mode_d  = plc_pkg::CM_INSERT;
					tgt     = IW'(pos_x - CMPW'(1));
					count_d = count_q + CW'(1);
				end
			end
			plc_pkg::K_APPEND: begin
				if (count_q == FULL_CNT) begin
					status_d = plc_pkg::ST_FULL;
				end else begin
					mode_d  = plc_pkg::CM_INSERT;
					tgt     = IW'(count_q);
					count_d = count_q + CW'(1);
				end
			end
			plc_pkg::K_DEL_POS: begin
				if (count_q == '0) begin
					status_d = plc_pkg::ST_EMPTY;
				end else if (pos_x == '0 || pos_x > n_x) begin
					status_d = plc_pkg::ST_BADPOS;
				end else begin
					mode_d  = plc_pkg::CM_DELETE;
					tgt     = IW'(pos_x - CMPW'(1));
					count_d = count_q - CW'(1);
				end
			end
			plc_pkg::K_DEL_VAL: begin
				if (count_q == '0) begin
					status_d = plc_pkg::ST_EMPTY;
				end else if (any_hit) begin
					found_d = 1'b1;
					mode_d  = plc_pkg::CM_DROP_HIT;
					count_d = count_q - CW'(1);
				end else begin
					status_d = plc_pkg::ST_MISSING;
				end
			end
			plc_pkg::K_SEARCH: begin
				if (count_q == '0) begin
					status_d = plc_pkg::ST_EMPTY;
				end else if (any_hit) begin
					found_d = 1'b1;
				end else begin
					status_d = plc_pkg::ST_MISSING;
				end
			end
			plc_pkg::K_DROP_TAIL: begin
				if (count_q == '0) begin
					status_d = plc_pkg::ST_EMPTY;
				end else begin
					count_d = count_q - CW'(1);
				end
			end
			default: begin
				status_d = plc_pkg::ST_OK;
			end
		endcase
	end

	// Drive the row only on an accepted word
	assign ctl.mode  = accept ? mode_d : plc_pkg::CM_HOLD;
	assign ctl.value = req.data.item_value;

	assign cnt_m1   = count_q - CW'(1);
	assign tail_idx = IW'(cnt_m1);
	assign mid_idx  = IW'(cnt_m1 >> 1);

	// Row of cells, each handing its entry and the hit mark to its neighbors
	assign hit_chain[0] = 1'b0;
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		plc_cell #(
			.IDX (i),
			.IW  (IW),
			.CW  (CW)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.tgt         (tgt),
			.count       (count_q),
			.left_value  ((i == 0) ? cell_val[i] : cell_val[(i == 0) ? 0 : i - 1]),
			.right_value ((i == CAPACITY - 1) ? cell_val[i] :
				cell_val[(i == CAPACITY - 1) ? i : i + 1]),
			.hit_in      (hit_chain[i]),
			.hit_out     (hit_chain[i+1]),
			.tail_idx    (tail_idx),
			.mid_idx     (mid_idx),
			.value       (cell_val[i]),
			.tail_pick   (tail_pick[i]),
			.mid_pick    (mid_pick[i])
		);
	end

	// Merge the tail and middle picks
	always_comb begin
		tail_v = '0;
		mid_v  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tail_v = tail_v | tail_pick[i];
			mid_v  = mid_v | mid_pick[i];
		end
	end

	// Hold the entry count, busy flag and pending status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			status_q    <= plc_pkg::ST_OK;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q  <= count_d;
				status_q <= status_d;
				found_q  <= found_d;
				busy_q   <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Load the response word from the updated row
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_data_q.status      <= status_q;
			rsp_data_q.found       <= found_q;
			rsp_data_q.entry_count <= plc_pkg::CNT_W'(count_q);
			if (count_q == '0) begin
				rsp_data_q.head_value   <= '0;
				rsp_data_q.tail_value   <= '0;
				rsp_data_q.middle_value <= '0;
			end else begin
				rsp_data_q.head_value   <= cell_val[0];
				rsp_data_q.tail_value   <= tail_v;
				rsp_data_q.middle_value <= mid_v;
			end
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// Checks
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_CNT)
		else $error("entry count above capacity");

	assert property (@(posedge clk) disable iff (!arst_n) !accept |=> $stable(count_q))
		else $error("entry count changed without a request word");

	assert property (@(posedge clk) disable iff (!arst_n) accept |=> busy_q && !req.ready)
		else $error("request side not blocked after accept");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.found |-> rsp.data.status == plc_pkg::ST_OK)
		else $error("found flag with a failing status");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.entry_count == '0 |->
		rsp.data.head_value == '0 && rsp.data.tail_value == '0)
		else $error("empty list reports nonzero entries");

endmodule
